### rtl/skrs_pkg.sv
// ---------------------------------------------------------------------------
// skrs_pkg
// Shared types and constants of the scalar Kalman range smoother.
// ---------------------------------------------------------------------------
package skrs_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_W      = 3;
    localparam int MEAS_W    = 24;
    localparam int PN_W      = 18;
    localparam int MN_W      = 24;
    localparam int TH_W      = 23;
    localparam int VAR_W     = 18;
    localparam int DEN_W     = 25;
    localparam int REM_W     = 26;
    localparam int K_W       = 17;
    localparam int MA_W      = 26;
    localparam int MB_W      = 18;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THRESHOLD = 2'd2;

    localparam logic [PN_W-1:0]  PN_RESET  = 18'd1311;
    localparam logic [MN_W-1:0]  MN_RESET  = 24'd327680;
    localparam logic [TH_W-1:0]  TH_RESET  = 23'd22016;
    localparam logic [VAR_W-1:0] VAR_RESET = 18'd65536;
    localparam logic [VAR_W-1:0] VAR_MAX   = 18'd262143;
    localparam logic [K_W-1:0]   ONE_Q16   = 17'd65536;
    localparam logic [PROD_W-1:0] HALF_Q16 = 44'd32768;

    typedef struct packed {
        logic load;
        logic pred;
        logic div_step;
        logic mul_k;
        logic mul_v;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic direct;
        logic out_full;
    } t_status;

endpackage

### rtl/skrs_ctrl.sv
// ---------------------------------------------------------------------------
// skrs_ctrl
// Sequencer of the smoother: steps one sample through prediction, the iterative
// gain division, the two shared multiplications and write-back, or direct to write-back.
// ---------------------------------------------------------------------------
module skrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_m_tready,
    input  skrs_pkg::t_status i_status,
    output skrs_pkg::t_cmd    o_cmd,
    output logic              o_s_tready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRED  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MULK  = 3'd3;
    localparam logic [2:0] S_MULV  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [skrs_pkg::CNT_W-1:0] r_cnt;
    logic [skrs_pkg::CNT_W-1:0] n_cnt;
    logic                       can_write;

    assign can_write  = !i_status.out_full || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.pred     = (r_state == S_PRED);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.mul_k    = (r_state == S_MULK);
        o_cmd.mul_v    = (r_state == S_MULV);
        o_cmd.write    = (r_state == S_WRITE) && can_write;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                n_cnt = '0;
                if (i_status.direct) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + skrs_pkg::CNT_W'(1);
                if (r_cnt == skrs_pkg::CNT_W'(skrs_pkg::DIV_STEPS - 1)) begin
                    n_state = S_MULK;
                end
            end
            S_MULK: begin
                n_state = S_MULV;
            end
            S_MULV: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (can_write) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> (!i_status.out_full || i_m_tready))
        else $error("result written over an untaken result");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < skrs_pkg::CNT_W'(skrs_pkg::DIV_STEPS)))
        else $error("division step counter overran");
    a_load_to_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_PRED))
        else $error("accepted sample did not enter prediction");
`endif

endmodule

### rtl/skrs_dpath.sv
// ---------------------------------------------------------------------------
// skrs_dpath
// Datapath of the smoother: per-channel state, configuration registers,
// restoring divider for the gain, shared multiplier and output register.
// ---------------------------------------------------------------------------
module skrs_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  skrs_pkg::t_cmd                  i_cmd,
    output skrs_pkg::t_status               o_status,
    input  logic [skrs_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [skrs_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [skrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skrs_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [skrs_pkg::PN_W-1:0]   r_pn;
    logic [skrs_pkg::MN_W-1:0]   r_mn;
    logic [skrs_pkg::TH_W-1:0]   r_th;

    logic [skrs_pkg::MEAS_W-1:0] r_est_mem [skrs_pkg::CHANNELS];
    logic [skrs_pkg::VAR_W-1:0]  r_var_mem [skrs_pkg::CHANNELS];
    logic [skrs_pkg::CHANNELS-1:0] r_seen;

    logic [skrs_pkg::CH_W-1:0]   r_ch;
    logic signed [skrs_pkg::MEAS_W-1:0] r_meas;
    logic                        r_direct;
    logic                        in_range;

    logic [skrs_pkg::VAR_W:0]    pp_sum;
    logic [skrs_pkg::VAR_W-1:0]  pp_c;
    logic [skrs_pkg::DEN_W-1:0]  den_c;
    logic [skrs_pkg::VAR_W-1:0]  r_pp;
    logic [skrs_pkg::DEN_W-1:0]  r_den;
    logic                        r_den_zero;
    logic signed [skrs_pkg::MEAS_W:0] r_diff;

    logic [skrs_pkg::REM_W-1:0]  r_rem;
    logic [skrs_pkg::K_W-1:0]    r_q;
    logic                        r_first;
    logic [skrs_pkg::REM_W-1:0]  trial;
    logic [skrs_pkg::REM_W:0]    trial_sub;
    logic [skrs_pkg::K_W-1:0]    k_c;

    logic signed [skrs_pkg::MA_W-1:0]   mul_a;
    logic signed [skrs_pkg::MB_W-1:0]   mul_b;
    logic signed [skrs_pkg::PROD_W-1:0] r_prod;
    logic signed [skrs_pkg::PROD_W-1:0] rnd_c;
    logic signed [skrs_pkg::MEAS_W:0]   x_c;
    logic signed [skrs_pkg::MEAS_W-1:0] r_x;

    logic signed [skrs_pkg::MEAS_W:0]   dev_c;
    logic [skrs_pkg::MEAS_W:0]          dev_abs;
    logic                               snap;
    logic [skrs_pkg::MEAS_W-1:0]        x_final;
    logic [skrs_pkg::VAR_W-1:0]         var_new;

    logic [skrs_pkg::MEAS_W-1:0]        r_out;
    logic                               r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn <= skrs_pkg::PN_RESET;
            r_mn <= skrs_pkg::MN_RESET;
            r_th <= skrs_pkg::TH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skrs_pkg::REG_PROCESS_NOISE:     r_pn <= i_cfg_data[skrs_pkg::PN_W-1:0];
                skrs_pkg::REG_MEASUREMENT_NOISE: r_mn <= i_cfg_data[skrs_pkg::MN_W-1:0];
                skrs_pkg::REG_OUTLIER_THRESHOLD: r_th <= i_cfg_data[skrs_pkg::TH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_range = ({1'b0, r_ch} < (skrs_pkg::CH_W + 1)'(skrs_pkg::CHANNELS));

    assign pp_sum = {1'b0, r_var_mem[r_ch]} + {1'b0, r_pn};
    assign pp_c   = pp_sum[skrs_pkg::VAR_W] ? skrs_pkg::VAR_MAX : pp_sum[skrs_pkg::VAR_W-1:0];
    assign den_c  = {7'b0, pp_c} + {1'b0, r_mn};

    assign o_status.direct   = !in_range || !r_seen[r_ch];
    assign o_status.out_full = r_out_full;

    assign trial     = r_first ? r_rem : {r_rem[skrs_pkg::REM_W-2:0], 1'b0};
    assign trial_sub = {1'b0, trial} - {2'b0, r_den};
    assign k_c       = r_den_zero ? '0 : r_q;

    always_comb begin
        if (i_cmd.mul_k) begin
            mul_a = skrs_pkg::MA_W'(r_diff);
            mul_b = {1'b0, k_c};
        end else begin
            mul_a = {8'b0, r_pp};
            mul_b = {1'b0, skrs_pkg::ONE_Q16 - k_c};
        end
    end

    assign rnd_c = r_prod + skrs_pkg::HALF_Q16;
    assign x_c   = {r_est_mem[r_ch][skrs_pkg::MEAS_W-1], r_est_mem[r_ch]}
                 + rnd_c[40:16];

    assign var_new = rnd_c[33:16];
    assign dev_c   = {r_x[skrs_pkg::MEAS_W-1], r_x} - {r_meas[skrs_pkg::MEAS_W-1], r_meas};
    assign dev_abs = dev_c[skrs_pkg::MEAS_W] ? (skrs_pkg::MEAS_W + 1)'(-dev_c)
                                              : (skrs_pkg::MEAS_W + 1)'(dev_c);
    assign snap    = (dev_abs >= {2'b0, r_th});
    assign x_final = (r_direct || snap) ? r_meas : r_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch   <= i_s_tdata[skrs_pkg::CH_W-1:0];
            r_meas <= i_s_tdata[skrs_pkg::CH_W +: skrs_pkg::MEAS_W];
        end
        if (i_cmd.pred) begin
            r_direct   <= o_status.direct;
            r_pp       <= pp_c;
            r_den      <= den_c;
            r_den_zero <= (den_c == '0);
            r_rem      <= {8'b0, pp_c};
            r_q        <= '0;
            r_first    <= 1'b1;
            r_diff     <= {r_meas[skrs_pkg::MEAS_W-1], r_meas}
                        - {r_est_mem[r_ch][skrs_pkg::MEAS_W-1], r_est_mem[r_ch]};
        end
        if (i_cmd.div_step) begin
            r_first <= 1'b0;
            if (!trial_sub[skrs_pkg::REM_W]) begin
                r_rem <= trial_sub[skrs_pkg::REM_W-1:0];
                r_q   <= {r_q[skrs_pkg::K_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[skrs_pkg::K_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_k || i_cmd.mul_v) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.mul_v) begin
            r_x <= x_c[skrs_pkg::MEAS_W-1:0];
        end
        if (i_cmd.write) begin
            r_out <= x_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int i = 0; i < skrs_pkg::CHANNELS; i++) begin
                r_est_mem[i] <= '0;
                r_var_mem[i] <= skrs_pkg::VAR_RESET;
            end
        end else if (i_cmd.write && in_range) begin
            r_seen[r_ch]    <= 1'b1;
            r_est_mem[r_ch] <= x_final;
            if (!r_direct) begin
                r_var_mem[r_ch] <= var_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_full <= 1'b1;
        end else if (i_m_tready) begin
            r_out_full <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_full;
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    a_direct_passes_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write && r_direct) |=> (r_out == $past(r_meas)))
        else $error("first sample did not pass the measurement through");
    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_v |-> (k_c <= skrs_pkg::ONE_Q16))
        else $error("gain above one");
    a_write_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> r_out_full)
        else $error("written result not presented");
`endif

endmodule

### rtl/scalar_kalman_range_smoother_unit.sv
// A sample passes through prediction, the restoring gain divider (one quotient bit
// per step), the two multiplications and write-back; a channel's first sample goes
// straight from prediction to write-back. One sample is processed at a time: a new
// sample is accepted once the last is written back; a waiting result stalls the
// next result only. Synchronous active-low reset restores the register defaults,
// clears all channel flags and estimates and sets every variance to 1.0.
// ---------------------------------------------------------------------------
// scalar_kalman_range_smoother_unit
// Per-channel scalar Kalman smoother for ranging samples with outlier snap.
// ---------------------------------------------------------------------------
module scalar_kalman_range_smoother_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tdata: channel [2:0], measurement [26:3], zero [31:27]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [skrs_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tdata: estimate [23:0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [skrs_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [skrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skrs_pkg::CFG_W-1:0]      i_cfg_data
);

    skrs_pkg::t_cmd    cmd;
    skrs_pkg::t_status status;

    skrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready)
    );

    skrs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule
